// File: design/mbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the marker bit matrix decoder.
// No dependencies; used by mbd_csr, mbd_decode and the top level.
package mbd_pkg;

   // Grid geometry
   localparam int GRID_DIM  = 7;
   localparam int CODE_DIM  = 5;
   localparam int TURNS     = 4;
   localparam int CELL_BITS = GRID_DIM * GRID_DIM;

   // Pattern reset values
   localparam logic [CODE_DIM-1:0] TOP_ROW_RESET    = 5'd17;
   localparam logic [CODE_DIM-1:0] BOTTOM_ROW_RESET = 5'd23;

   // Register map, indexed by paddr[2]
   localparam logic REG_TOP_ROW    = 1'b0;
   localparam logic REG_BOTTOM_ROW = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DECODED = 2'd0,
      STATUS_BORDER  = 2'd1,
      STATUS_CODE    = 2'd2
   } status_type;

   typedef struct packed {
      status_type          status;
      logic [1:0]          rotation;
      logic [3:0]          best_distance;
      logic [CODE_DIM-1:0] map_id;
      logic [CODE_DIM-1:0] sector_id;
      logic [CODE_DIM-1:0] marker_id;
   } result_type;

   typedef struct packed {
      logic [CODE_DIM-1:0] top_row;
      logic [CODE_DIM-1:0] bottom_row;
   } patterns_type;

   // Mask of the 24 border cells, bit y*7+x
   function automatic logic [CELL_BITS-1:0] border_mask();
      logic [CELL_BITS-1:0] m;
      m = '0;
      for (int y = 0; y < GRID_DIM; y++) begin
         for (int x = 0; x < GRID_DIM; x++) begin
            if (x == 0 || x == GRID_DIM - 1 || y == 0 || y == GRID_DIM - 1) begin
               m[y*GRID_DIM + x] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   localparam logic [CELL_BITS-1:0] BORDER_MASK = border_mask();

endpackage

// File: design/mbd_csr.sv
`timescale 1ns / 1ps
// APB-style register block holding the two template row patterns.
// Depends on mbd_pkg.
module mbd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready,
   output mbd_pkg::patterns_type patterns
);

   logic [mbd_pkg::CODE_DIM-1:0] top_row_ff, top_row_in;
   logic [mbd_pkg::CODE_DIM-1:0] bottom_row_ff, bottom_row_in;
   logic                          write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   // Register write decode; only the low five data bits are kept
   always_comb begin
      top_row_in    = top_row_ff;
      bottom_row_in = bottom_row_ff;
      if (write_en) begin
         case (csr_paddr[2])
            mbd_pkg::REG_TOP_ROW:    top_row_in    = csr_pwdata[mbd_pkg::CODE_DIM-1:0];
            mbd_pkg::REG_BOTTOM_ROW: bottom_row_in = csr_pwdata[mbd_pkg::CODE_DIM-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_row_ff    <= mbd_pkg::TOP_ROW_RESET;
         bottom_row_ff <= mbd_pkg::BOTTOM_ROW_RESET;
      end else begin
         top_row_ff    <= top_row_in;
         bottom_row_ff <= bottom_row_in;
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         mbd_pkg::REG_TOP_ROW:    csr_prdata[mbd_pkg::CODE_DIM-1:0] = top_row_ff;
         mbd_pkg::REG_BOTTOM_ROW: csr_prdata[mbd_pkg::CODE_DIM-1:0] = bottom_row_ff;
         default: ;
      endcase
   end

   assign patterns.top_row    = top_row_ff;
   assign patterns.bottom_row = bottom_row_ff;

endmodule

// File: design/mbd_decode.sv
`timescale 1ns / 1ps
// Combinational marker decode: border check, four rotations, template
// distance, best rotation pick and id extraction. Depends on mbd_pkg.
module mbd_decode (
   input  logic [mbd_pkg::CELL_BITS-1:0] cell_bits,
   input  mbd_pkg::patterns_type          patterns,
   output mbd_pkg::result_type            result
);

   localparam int CD = mbd_pkg::CODE_DIM;

   // rows[t][i]: code row i at t quarter turns, column 0 in the MSB
   logic [CD-1:0] rows [mbd_pkg::TURNS][CD];
   logic [3:0]    miss_count [mbd_pkg::TURNS];
   logic          border_ok;
   logic [1:0]    best_t;
   logic [3:0]    best_d;
   logic [CD-1:0] top_diff, bot_diff;

   assign border_ok = ~|(cell_bits & mbd_pkg::BORDER_MASK);

   // Rotations by rewiring of the inner 5x5 cells
   always_comb begin
      int si, sj;
      for (int t = 0; t < mbd_pkg::TURNS; t++) begin
         for (int i = 0; i < CD; i++) begin
            for (int j = 0; j < CD; j++) begin
               case (t)
                  1:       begin si = CD - 1 - j; sj = i;          end
                  2:       begin si = CD - 1 - i; sj = CD - 1 - j; end
                  3:       begin si = j;          sj = CD - 1 - i; end
                  default: begin si = i;          sj = j;          end
               endcase
               rows[t][i][CD-1-j] = cell_bits[(si + 1) * mbd_pkg::GRID_DIM + sj + 1];
            end
         end
      end
   end

   // Template mismatch count per rotation
   always_comb begin
      for (int t = 0; t < mbd_pkg::TURNS; t++) begin
         top_diff      = rows[t][0] ^ patterns.top_row;
         bot_diff      = rows[t][CD-1] ^ patterns.bottom_row;
         miss_count[t] = 4'($countones(top_diff)) + 4'($countones(bot_diff));
      end
   end

   // Fewest mismatches, lowest rotation on ties
   always_comb begin
      best_t = 2'd0;
      best_d = miss_count[0];
      for (int t = 1; t < mbd_pkg::TURNS; t++) begin
         if (miss_count[t] < best_d) begin
            best_d = miss_count[t];
            best_t = 2'(t);
         end
      end
   end

   // Result assembly
   always_comb begin
      result = '0;
      if (!border_ok) begin
         result.status = mbd_pkg::STATUS_BORDER;
      end else if (best_d != 4'd0) begin
         result.status        = mbd_pkg::STATUS_CODE;
         result.rotation      = best_t;
         result.best_distance = best_d;
      end else begin
         result.status    = mbd_pkg::STATUS_DECODED;
         result.rotation  = best_t;
         result.map_id    = rows[best_t][1];
         result.sector_id = rows[best_t][2];
         result.marker_id = rows[best_t][3];
      end
   end

endmodule

// File: design/marker_bit_matrix_decoder.sv
`timescale 1ns / 1ps
// Marker bit matrix decoder, top level. Depends on mbd_pkg, mbd_csr, mbd_decode.
// Stages: input register, decode logic, result register. A request accepted into
// the input register is registered as a result once the result register is free.
// Throughput: one request per cycle while rsp_ready stays high.
// A waiting result holds the input register; req_ready drops once that is full too.
// Reset (synchronous): pipeline empties, patterns return to 17 (top) and 23 (bottom).
module marker_bit_matrix_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [48:0] req_cell_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_rotation,
   output logic [3:0]  rsp_best_distance,
   output logic [4:0]  rsp_map_id,
   output logic [4:0]  rsp_sector_id,
   output logic [4:0]  rsp_marker_id,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   mbd_pkg::patterns_type patterns;
   mbd_pkg::result_type   decoded;

   logic                             in_valid_ff, in_valid_in;
   logic [mbd_pkg::CELL_BITS-1:0]    cell_ff;
   logic                             out_valid_ff, out_valid_in;
   mbd_pkg::result_type              result_ff;
   logic                             out_load;
   logic                             in_load;

   mbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .patterns    (patterns)
   );

   mbd_decode u_decode (
      .cell_bits (cell_ff),
      .patterns  (patterns),
      .result    (decoded)
   );

   // Stage handshake: result register loads from a full input register when empty or being drained
   assign out_load     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || out_load;
   assign in_load      = req_valid && req_ready;
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         cell_ff <= req_cell_bits;
      end
      if (out_load) begin
         result_ff <= decoded;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = result_ff.status;
   assign rsp_rotation      = result_ff.rotation;
   assign rsp_best_distance = result_ff.best_distance;
   assign rsp_map_id        = result_ff.map_id;
   assign rsp_sector_id     = result_ff.sector_id;
   assign rsp_marker_id     = result_ff.marker_id;

endmodule
